### sv/thq_pkg.sv
// ----------------------------------------------------------------------------
// thq_pkg
// Shared types, constants and a helper function for the timer heap queue.
// ----------------------------------------------------------------------------
package thq_pkg;

   localparam int DefaultCapacity = 32;
   localparam int TimeWidth       = 48;
   localparam int IdWidth         = 16;
   localparam int PayloadWidth    = 32;
   localparam int DelayWidth      = 32;
   localparam int ElapsedWidth    = 20;

   localparam logic [TimeWidth-1:0] TimeLimit = {TimeWidth{1'b1}};

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_CANCEL   = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_EXPIRY   = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_UNUSED    = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]              command;
      logic [DelayWidth-1:0]   delay_len;
      logic [IdWidth-1:0]      cancel_id;
      logic [PayloadWidth-1:0] payload;
      logic [ElapsedWidth-1:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [1:0]              status;
      logic [IdWidth-1:0]      result_id;
      logic [PayloadWidth-1:0] expired_payload;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0]    deadline;
      logic [IdWidth-1:0]      ident;
      logic [PayloadWidth-1:0] payload;
      logic                    cancelled;
      logic [IdWidth-1:0]      sequence_id;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_TICK_ROOT,
      ST_TICK_CHECK,
      ST_DOWN_LAST,
      ST_DOWN_LEFT,
      ST_DOWN_RIGHT,
      ST_DOWN_CMP,
      ST_FINISH
   } state_type;

   // Key order: deadline first, then wrapping sequence compare.
   function automatic logic key_less(entry_type a, entry_type b);
      logic [IdWidth-1:0] d;
      d = b.sequence_id - a.sequence_id;
      if (a.deadline != b.deadline) begin
         return a.deadline < b.deadline;
      end
      return (d != '0) && !d[IdWidth-1];
   endfunction

endpackage

### sv/thq_if.sv
// ----------------------------------------------------------------------------
// thq_req_if / thq_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface thq_req_if;
   import thq_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface thq_rsp_if;
   import thq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/thq_heap_mem.sv
// ----------------------------------------------------------------------------
// thq_heap_mem
// Heap entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module thq_heap_mem #(
   parameter int Capacity = thq_pkg::DefaultCapacity
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(Capacity)-1:0]   wr_addr,
   input  thq_pkg::entry_type            wr_data,
   input  logic [$clog2(Capacity)-1:0]   rd_addr,
   output thq_pkg::entry_type            rd_data
);
   import thq_pkg::*;

   entry_type mem [Capacity];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/timer_heap_queue_top.sv
// ----------------------------------------------------------------------------
// timer_heap_queue_top
// Timer queue over a binary min-heap with one memory port pair.
// ----------------------------------------------------------------------------
// One request is taken at a time. The heap lives in a memory with one write
// port and one registered read port, and one key comparator is reused by a
// sequencer, so the cost is set by memory reads. A schedule climbs up to
// log2 CAPACITY levels, a cancel scans up to the current entry count of
// slots, and a tick sifts down once for each entry it removes. Each response
// sits in an output register until taken; an expiry is held back one step so
// the final one can carry the last flag, and the sequencer waits whenever it
// has a response to hand over while the output register is still occupied.
// The next request is accepted once the last response of the current one is
// taken.
module timer_heap_queue_top #(
   parameter int CAPACITY = thq_pkg::DefaultCapacity
) (
   input logic clock,
   input logic reset,
   thq_req_if.sink   req_ch,
   thq_rsp_if.source rsp_ch
);
   import thq_pkg::*;

   localparam int AddrWidth  = $clog2(CAPACITY);
   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam logic [CountWidth-1:0] CapCount = CountWidth'(CAPACITY);

   state_type state_ff, state_in;

   logic [CountWidth-1:0]   count_ff, count_in;
   logic [TimeWidth-1:0]    time_ff, time_in;
   logic [IdWidth-1:0]      next_id_ff, next_id_in;
   logic [IdWidth-1:0]      target_ff, target_in;
   logic [CountWidth-1:0]   idx_ff, idx_in;     // current slot in a sift or scan
   logic [CountWidth-1:0]   pick_ff, pick_in;
   entry_type               cur_ff, cur_in;     // entry being sifted
   entry_type               other_ff, other_in; // best of entry and left child
   rsp_type                 out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 pending_ff, pending_in;
   logic                    held_ff, held_in;

   logic                    out_free;
   logic                    wr_en;
   logic [AddrWidth-1:0]    wr_addr, rd_addr;
   entry_type               wr_data, rd_data;

   logic [TimeWidth:0]      sum_wide;
   logic [CountWidth:0]     left_w, right_w;

   function automatic rsp_type make_rsp(kind_type k, status_type s,
                                        logic [IdWidth-1:0] id,
                                        logic [PayloadWidth-1:0] pl, logic lst);
      rsp_type r;
      r.kind            = k;
      r.status          = s;
      r.result_id       = id;
      r.expired_payload = pl;
      r.last            = lst;
      return r;
   endfunction

   thq_heap_mem #(.Capacity(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign left_w  = {idx_ff, 1'b1};
   assign right_w = {idx_ff, 1'b0} + (CountWidth+1)'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         next_id_ff   <= '0;
         out_valid_ff <= 1'b0;
         held_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         next_id_ff   <= next_id_in;
         out_valid_ff <= out_valid_in;
         held_ff      <= held_in;
      end
      target_ff  <= target_in;
      idx_ff     <= idx_in;
      pick_ff    <= pick_in;
      cur_ff     <= cur_in;
      other_ff   <= other_in;
      out_ff     <= out_in;
      pending_ff <= pending_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      next_id_in   = next_id_ff;
      target_in    = target_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      cur_in       = cur_ff;
      other_in     = other_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      pending_in   = pending_ff;
      held_in      = held_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      rd_addr      = '0;
      sum_wide     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               unique case (command_type'(req_ch.data.command))
                  CMD_SCHEDULE: begin
                     if (count_ff == CapCount) begin
                        out_in       = make_rsp(KIND_SCHEDULE, STATUS_FULL, '0, '0, 1'b1);
                        out_valid_in = 1'b1;
                     end else begin
                        sum_wide = {1'b0, time_ff} + (TimeWidth+1)'(req_ch.data.delay_len);
                        cur_in.deadline    = sum_wide[TimeWidth] ? TimeLimit
                                                                 : sum_wide[TimeWidth-1:0];
                        cur_in.ident       = next_id_ff;
                        cur_in.payload     = req_ch.data.payload;
                        cur_in.cancelled   = 1'b0;
                        cur_in.sequence_id = next_id_ff;
                        next_id_in         = next_id_ff + IdWidth'(1);
                        idx_in             = count_ff;
                        count_in           = count_ff + CountWidth'(1);
                        state_in           = ST_UP_READ;
                     end
                  end
                  CMD_CANCEL: begin
                     target_in = req_ch.data.cancel_id;
                     idx_in    = '0;
                     state_in  = ST_SEARCH;
                  end
                  CMD_TICK: begin
                     sum_wide = {1'b0, time_ff} + (TimeWidth+1)'(req_ch.data.elapsed_us);
                     time_in  = sum_wide[TimeWidth] ? TimeLimit : sum_wide[TimeWidth-1:0];
                     held_in  = 1'b0;
                     state_in = ST_TICK_ROOT;
                  end
                  CMD_NONE: begin
                  end
               endcase
            end
         end

         // Sift up: cur_ff is the new entry, sitting logically at idx_ff.
         ST_UP_READ: begin
            if (idx_ff == '0) begin
               wr_en        = 1'b1;
               wr_addr      = '0;
               out_in       = make_rsp(KIND_SCHEDULE, STATUS_OK, cur_ff.ident, '0, 1'b1);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               pick_in  = (idx_ff - CountWidth'(1)) >> 1;
               rd_addr  = AddrWidth'((idx_ff - CountWidth'(1)) >> 1);
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en   = 1'b1;
            wr_addr = AddrWidth'(idx_ff);
            if (key_less(cur_ff, rd_data)) begin
               wr_data  = rd_data;  // move parent down
               idx_in   = pick_ff;
               state_in = ST_UP_READ;
            end else begin
               out_in       = make_rsp(KIND_SCHEDULE, STATUS_OK, cur_ff.ident, '0, 1'b1);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         // Linear scan: issue the read, compare on the next cycle.
         ST_SEARCH: begin
            if (idx_ff >= count_ff) begin
               out_in       = make_rsp(KIND_CANCEL, STATUS_NOT_FOUND, target_ff, '0, 1'b1);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_addr  = AddrWidth'(idx_ff);
               pick_in  = idx_ff;
               idx_in   = idx_ff + CountWidth'(1);
               state_in = ST_SEARCH_CMP;
            end
         end

         ST_SEARCH_CMP: begin
            if (rd_data.ident == target_ff) begin
               wr_en             = 1'b1;
               wr_addr           = AddrWidth'(pick_ff);
               wr_data           = rd_data;
               wr_data.cancelled = 1'b1;
               out_in            = make_rsp(KIND_CANCEL, STATUS_OK, target_ff, '0, 1'b1);
               out_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end

         // Tick: read the root and check it against time.
         ST_TICK_ROOT: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rd_addr  = '0;
               state_in = ST_TICK_CHECK;
            end
         end

         ST_TICK_CHECK: begin
            rd_addr = '0;  // keep the root on rd_data while stalled
            if (rd_data.deadline <= time_ff) begin
               if (!rd_data.cancelled && held_ff && !out_free) begin
                  state_in = ST_TICK_CHECK;
               end else begin
                  if (!rd_data.cancelled) begin
                     // Release the held expiry, hold this one.
                     if (held_ff) begin
                        out_in       = pending_ff;
                        out_valid_in = 1'b1;
                     end
                     pending_in = make_rsp(KIND_EXPIRY, STATUS_OK, rd_data.ident,
                                           rd_data.payload, 1'b0);
                     held_in    = 1'b1;
                  end
                  count_in = count_ff - CountWidth'(1);
                  rd_addr  = AddrWidth'(count_ff - CountWidth'(1));
                  state_in = ST_DOWN_LAST;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_DOWN_LAST: begin
            // rd_data is the old last entry; sift it down from the root.
            if (count_ff == '0) begin
               state_in = ST_TICK_ROOT;
            end else begin
               cur_in   = rd_data;
               idx_in   = '0;
               state_in = ST_DOWN_LEFT;
            end
         end

         ST_DOWN_LEFT: begin
            if (left_w >= {1'b0, count_ff}) begin
               wr_en    = 1'b1;
               wr_addr  = AddrWidth'(idx_ff);
               state_in = ST_TICK_ROOT;
            end else begin
               rd_addr  = AddrWidth'(left_w);
               state_in = ST_DOWN_RIGHT;
            end
         end

         ST_DOWN_RIGHT: begin
            // rd_data is the left child.
            if (key_less(rd_data, cur_ff)) begin
               other_in = rd_data;
               pick_in  = CountWidth'(left_w);
            end else begin
               other_in = cur_ff;
               pick_in  = idx_ff;
            end
            rd_addr  = AddrWidth'(right_w);
            state_in = ST_DOWN_CMP;
         end

         ST_DOWN_CMP: begin
            // rd_data is the right child, valid only below count_ff.
            wr_en   = 1'b1;
            wr_addr = AddrWidth'(idx_ff);
            if (right_w < {1'b0, count_ff} && key_less(rd_data, other_ff)) begin
               wr_data  = rd_data;
               idx_in   = CountWidth'(right_w);
               state_in = ST_DOWN_LEFT;
            end else if (pick_ff != idx_ff) begin
               wr_data  = other_ff;
               idx_in   = pick_ff;
               state_in = ST_DOWN_LEFT;
            end else begin
               state_in = ST_TICK_ROOT;
            end
         end

         // Close a tick: hand over the held expiry with the last flag.
         ST_FINISH: begin
            if (!held_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in       = pending_ff;
               out_in.last  = 1'b1;
               out_valid_in = 1'b1;
               held_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid);

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(rsp_ch.data));

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount);

   a_ready_clear: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid && state_ff == ST_IDLE);

endmodule
